FILE: design/pal_pkg.sv
package pal_pkg;

  // List geometry, fixed by the widths of the position and length fields
  localparam int unsigned DEPTH  = 64;
  localparam int unsigned POS_W  = 6;
  localparam int unsigned LEN_W  = 7;
  localparam int unsigned DATA_W = 32;

  // Register file: one register, byte address 4*index
  localparam int unsigned ADDR_W = 3;
  localparam int unsigned IDX_W  = ADDR_W - 2;
  localparam logic [IDX_W-1:0] REG_CAPACITY = IDX_W'(0);
  localparam logic [LEN_W-1:0] CAP_RESET    = LEN_W'(64);

  // Request codes
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_DELETE = 2'd1,
    FN_GET    = 2'd2,
    FN_CLEAR  = 2'd3
  } func_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  // Per-cycle move of the cell row
  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_INSERT = 2'd1,
    CELL_DELETE = 2'd2
  } cell_op_t;

  // Broadcast control to every cell
  typedef struct packed {
    cell_op_t           op;
    logic [POS_W-1:0]   pos;
  } cell_ctrl_t;

endpackage

FILE: design/positional_array_list_top.sv
// Channel   | Ports                                          | Direction
// ----------+------------------------------------------------+----------
// request   | in_valid/in_ready, in_func, in_position,       | in
//           | in_item_value                                  |
// result    | out_valid/out_ready, out_status,               | out
//           | out_read_value, out_list_length                |
// config    | psel, penable, pwrite, paddr, pwdata,          | in/out
//           | prdata, pready                                 |
//
// One request per cycle while in_ready is high; the result beat is registered.
// The row of 64 entry cells shifts up or down in parallel, and a read
// is one 64-way AND-OR over the cells, which sets the cycle.
// Reset clears the length, the output valid and sets the capacity to 64;
// entry cells are not reset and are read only below the length.
// in_ready drops only while a result beat is held and out_ready is low.
module positional_array_list_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    in_func,
  input  logic [pal_pkg::POS_W-1:0]     in_position,
  input  logic [pal_pkg::DATA_W-1:0]    in_item_value,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [1:0]                    out_status,
  output logic [pal_pkg::DATA_W-1:0]    out_read_value,
  output logic [pal_pkg::LEN_W-1:0]     out_list_length,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [pal_pkg::ADDR_W-1:0]    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned DEPTH = pal_pkg::DEPTH;

  logic [pal_pkg::LEN_W-1:0]   len_r;
  logic [pal_pkg::LEN_W-1:0]   len_nxt;
  logic [pal_pkg::LEN_W-1:0]   cap_r;
  logic                        out_valid_r;
  logic [1:0]                  out_status_r;
  logic [pal_pkg::DATA_W-1:0]  out_read_value_r;
  logic [pal_pkg::LEN_W-1:0]   out_list_length_r;

  logic                        fire;
  logic                        full;
  logic                        in_range;
  logic [pal_pkg::LEN_W-1:0]   pos_ext;
  logic [pal_pkg::POS_W-1:0]   ins_pos;
  pal_pkg::func_t              func;
  pal_pkg::status_t            status;
  logic [pal_pkg::DATA_W-1:0]  read_word;
  logic [pal_pkg::DATA_W-1:0]  sel_word;
  pal_pkg::cell_ctrl_t         ctrl;

  logic [pal_pkg::DATA_W-1:0]  cell_q  [DEPTH];
  logic [pal_pkg::DATA_W-1:0]  cell_rd [DEPTH];

  // Register port: write on access phase, read back capacity
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= pal_pkg::CAP_RESET;
    end else if (psel && penable && pwrite && pready &&
                 paddr[pal_pkg::ADDR_W-1:2] == pal_pkg::REG_CAPACITY) begin
      cap_r <= pwdata[pal_pkg::LEN_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr[pal_pkg::ADDR_W-1:2] == pal_pkg::REG_CAPACITY) begin
      prdata = {{(32 - pal_pkg::LEN_W){1'b0}}, cap_r};
    end
  end

  // Accept a beat whenever the result register is free or draining
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;
  assign func     = pal_pkg::func_t'(in_func);

  assign pos_ext  = {1'b0, in_position};
  assign full     = (len_r >= cap_r) || (len_r >= pal_pkg::LEN_W'(DEPTH));
  assign in_range = pos_ext < len_r;
  assign ins_pos  = (pos_ext > len_r) ? len_r[pal_pkg::POS_W-1:0] : in_position;

  // OR together the addressed cell's word
  always_comb begin
    sel_word = '0;
    for (int i = 0; i < DEPTH; i++) begin
      sel_word = sel_word | cell_rd[i];
    end
  end

  // Decode the request into a cell move, a status, the read word and the new length
  always_comb begin
    ctrl.op   = pal_pkg::CELL_HOLD;
    ctrl.pos  = in_position;
    status    = pal_pkg::ST_OK;
    read_word = '0;
    len_nxt   = len_r;
    unique case (func)
      pal_pkg::FN_INSERT: begin
        ctrl.pos = ins_pos;
        if (full) begin
          status = pal_pkg::ST_FULL;
        end else begin
          ctrl.op = pal_pkg::CELL_INSERT;
          len_nxt = len_r + pal_pkg::LEN_W'(1);
        end
      end
      pal_pkg::FN_DELETE: begin
        if (!in_range) begin
          status = pal_pkg::ST_RANGE;
        end else begin
          ctrl.op   = pal_pkg::CELL_DELETE;
          read_word = sel_word;
          len_nxt   = len_r - pal_pkg::LEN_W'(1);
        end
      end
      pal_pkg::FN_GET: begin
        if (!in_range) begin
          status = pal_pkg::ST_RANGE;
        end else begin
          read_word = sel_word;
        end
      end
      pal_pkg::FN_CLEAR: begin
        len_nxt = '0;
      end
    endcase
    if (!fire) begin
      ctrl.op = pal_pkg::CELL_HOLD;
      len_nxt = len_r;
    end
  end

  // Row of entry cells, each passing its word to both neighbors
  for (genvar g = 0; g < DEPTH; g++) begin : g_cell
    logic [pal_pkg::DATA_W-1:0] left_w;
    logic [pal_pkg::DATA_W-1:0] right_w;

    if (g == 0) begin : g_first
      assign left_w = in_item_value;
    end else begin : g_mid_l
      assign left_w = cell_q[g-1];
    end

    if (g == DEPTH - 1) begin : g_last
      assign right_w = cell_q[g];
    end else begin : g_mid_r
      assign right_w = cell_q[g+1];
    end

    pal_cell #(
      .CELL_IDX (g)
    ) u_cell (
      .clk      (clk),
      .ctrl     (ctrl),
      .word_in  (in_item_value),
      .left_in  (left_w),
      .right_in (right_w),
      .data_out (cell_q[g]),
      .rd_out   (cell_rd[g])
    );
  end

  // Length and result valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      if (fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Capture the result beat
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status_r      <= status;
      out_read_value_r  <= read_word;
      out_list_length_r <= len_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_read_value  = out_read_value_r;
  assign out_list_length = out_list_length_r;

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= pal_pkg::LEN_W'(DEPTH))
    else $error("list length beyond depth");

  a_full_holds: assert property (@(posedge clk) disable iff (!rst_n)
    fire && func == pal_pkg::FN_INSERT && full |=> len_r == $past(len_r))
    else $error("refused insert changed the length");

  a_ins_grows: assert property (@(posedge clk) disable iff (!rst_n)
    fire && func == pal_pkg::FN_INSERT && !full
    |=> len_r == $past(len_r) + pal_pkg::LEN_W'(1))
    else $error("insert did not grow the list");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_status_r != pal_pkg::ST_OK |-> out_read_value_r == '0)
    else $error("error result carries data");
`endif

endmodule

FILE: design/pal_cell.sv
module pal_cell #(
  parameter int unsigned CELL_IDX = 0
) (
  input  logic                        clk,
  input  pal_pkg::cell_ctrl_t         ctrl,
  input  logic [pal_pkg::DATA_W-1:0]  word_in,
  input  logic [pal_pkg::DATA_W-1:0]  left_in,
  input  logic [pal_pkg::DATA_W-1:0]  right_in,
  output logic [pal_pkg::DATA_W-1:0]  data_out,
  output logic [pal_pkg::DATA_W-1:0]  rd_out
);

  localparam logic [pal_pkg::POS_W-1:0] MY_IDX = pal_pkg::POS_W'(CELL_IDX);

  logic [pal_pkg::DATA_W-1:0] data_r;
  logic [pal_pkg::DATA_W-1:0] data_nxt;

  // Pick the next word: load, take from below, take from above, or hold
  always_comb begin
    data_nxt = data_r;
    unique case (ctrl.op)
      pal_pkg::CELL_INSERT: begin
        if (MY_IDX == ctrl.pos) begin
          data_nxt = word_in;
        end else if (MY_IDX > ctrl.pos) begin
          data_nxt = left_in;
        end
      end
      pal_pkg::CELL_DELETE: begin
        if (MY_IDX >= ctrl.pos) begin
          data_nxt = right_in;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // Drive the shared read bus only when addressed
  assign data_out = data_r;
  assign rd_out   = (MY_IDX == ctrl.pos) ? data_r : '0;

endmodule
